// ===== hw/rtl/fnas_pkg.sv =====
package fnas_pkg;

    // Grid and sample geometry
    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 4096;
    localparam int SAMPLE_BITS     = 32;
    localparam int AVG_BITS        = SAMPLE_BITS + 2;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int ROW_BITS        = 13;
    localparam int OUT_ROW_BITS    = 12;
    localparam int OUT_COL_BITS    = 10;

    // Register port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_index_t;

    typedef logic [COL_BITS-1:0]           col_t;
    typedef logic [ROW_BITS-1:0]           row_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [AVG_BITS-1:0]    avg_t;

    // Line buffer read request (issued when a transaction is accepted)
    typedef struct packed {
        logic en;
        col_t addr0;
        col_t addr1;
    } lb_rd_t;

    // Line buffer write-back (issued when the stage-1 item retires)
    typedef struct packed {
        logic    en;
        col_t    addr;
        sample_t prev_data;
        sample_t old_data;
    } lb_wr_t;

endpackage

// ===== hw/rtl/four_neighbor_average_stencil_top.sv =====
// A result is loaded into the output register when its stage-1 item advances, after the
//   transaction that completes it is accepted (results run one grid row behind the input).
// Throughput: one transaction per cycle unless a result stalls on m_ready; set by the two
//   line-buffer memories (one write each; prev_mem read twice, old_mem once; registered reads).
// Reset (aresetn, synchronous, active low): positions, valids and registers
//   return to defaults (width 1, height 1); line-buffer contents are not cleared.
module four_neighbor_average_stencil_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input sample stream
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  fnas_pkg::sample_t                      s_sample,
    input  logic                                   s_flush,
    // result stream
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output fnas_pkg::avg_t                         m_average,
    output logic [fnas_pkg::OUT_ROW_BITS-1:0]      m_out_row,
    output logic [fnas_pkg::OUT_COL_BITS-1:0]      m_out_col,
    output logic                                   m_last,
    // register port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fnas_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [fnas_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [fnas_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);
    import fnas_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_REG_BITS-1:0]  grid_width_reg;
    logic [HEIGHT_REG_BITS-1:0] grid_height_reg;
    logic                       cfg_wr;
    reg_index_t                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= WIDTH_REG_BITS'(1);
            grid_height_reg <= HEIGHT_REG_BITS'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[WIDTH_REG_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[HEIGHT_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GRID_WIDTH:  prdata = APB_DATA_BITS'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = APB_DATA_BITS'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

    // Effective geometry: zero means one, oversize saturates.
    logic [WIDTH_REG_BITS-1:0]  w_eff;
    logic [HEIGHT_REG_BITS-1:0] h_eff;

    always_comb begin
        if (grid_width_reg == '0)
            w_eff = WIDTH_REG_BITS'(1);
        else if (grid_width_reg > WIDTH_REG_BITS'(MAX_WIDTH))
            w_eff = WIDTH_REG_BITS'(MAX_WIDTH);
        else
            w_eff = grid_width_reg;
        if (grid_height_reg == '0)
            h_eff = HEIGHT_REG_BITS'(1);
        else if (grid_height_reg > HEIGHT_REG_BITS'(MAX_HEIGHT))
            h_eff = HEIGHT_REG_BITS'(MAX_HEIGHT);
        else
            h_eff = grid_height_reg;
    end

    // ------------------------------------------------------------------
    // Front end: raster position, line-buffer reads on accept
    // ------------------------------------------------------------------
    logic                      s_accept;
    col_t                      col_reg, col_next;
    row_t                      row_reg, row_next;
    col_t                      c_cur, c_plus1;
    row_t                      r_cur;
    logic [WIDTH_REG_BITS-1:0] c_wide_plus1;
    logic                      cur_flush_row;
    logic                      cur_last_col;

    assign s_accept = s_valid && s_ready;

    always_comb begin
        // A column past the width restarts at zero; a row past the height
        // is treated as the flush row.
        c_cur = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        r_cur = (row_reg > h_eff) ? h_eff : row_reg;
        c_wide_plus1  = WIDTH_REG_BITS'(c_cur) + WIDTH_REG_BITS'(1);
        c_plus1       = c_wide_plus1[COL_BITS-1:0];
        cur_flush_row = (r_cur >= h_eff);
        cur_last_col  = (c_wide_plus1 >= w_eff);
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (cur_last_col) begin
                col_next = '0;
                row_next = cur_flush_row ? '0 : r_cur + ROW_BITS'(1);
            end else begin
                col_next = c_plus1;
                row_next = r_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line-buffer data arrives, sum formed, write-back on retire
    // ------------------------------------------------------------------
    logic    s1_valid_reg;
    col_t    s1_col_reg;
    row_t    s1_row_reg;
    logic    s1_flush_row_reg;
    logic    s1_last_col_reg;
    sample_t s1_down_reg;
    sample_t left_hold_reg;

    logic    s1_has_result;
    logic    s1_adv;
    sample_t here, up, left, right;
    avg_t    sum;
    lb_rd_t  lb_rd;
    lb_wr_t  lb_wr;
    sample_t prev0_q, prev1_q, old_q;

    logic    m_valid_reg;
    avg_t    m_average_reg;
    logic [OUT_ROW_BITS-1:0] m_out_row_reg;
    logic [OUT_COL_BITS-1:0] m_out_col_reg;
    logic    m_last_reg;

    // First grid row only fills the buffers; every later row emits.
    assign s1_has_result = (s1_row_reg != '0);
    assign s1_adv        = s1_valid_reg && (!s1_has_result || !m_valid_reg || m_ready);
    assign s_ready       = !s1_valid_reg || s1_adv;

    assign lb_rd.en    = s_accept;
    assign lb_rd.addr0 = c_cur;
    assign lb_rd.addr1 = c_plus1;

    fnas_line_buf u_line_buf (
        .aclk    (aclk),
        .rd      (lb_rd),
        .wr      (lb_wr),
        .prev0_q (prev0_q),
        .prev1_q (prev1_q),
        .old_q   (old_q)
    );

    always_comb begin
        here  = prev0_q;
        up    = (s1_row_reg >= ROW_BITS'(2)) ? old_q : '0;
        left  = (s1_col_reg != '0) ? left_hold_reg : '0;
        right = s1_last_col_reg ? '0 : prev1_q;
        sum   = AVG_BITS'(up) + AVG_BITS'(s1_down_reg) + AVG_BITS'(left) + AVG_BITS'(right);
    end

    // Row shift: current row above moves to the older store, the new
    // sample becomes the row above.
    assign lb_wr.en        = s1_adv;
    assign lb_wr.addr      = s1_col_reg;
    assign lb_wr.prev_data = s1_down_reg;
    assign lb_wr.old_data  = here;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_col_reg       <= c_cur;
            s1_row_reg       <= r_cur;
            s1_flush_row_reg <= cur_flush_row;
            s1_last_col_reg  <= cur_last_col;
            s1_down_reg      <= (cur_flush_row || s_flush) ? '0 : s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_hold_reg <= '0;
        end else if (s1_adv) begin
            left_hold_reg <= here;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv && s1_has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_has_result) begin
            m_average_reg <= sum;
            m_out_row_reg <= OUT_ROW_BITS'(s1_row_reg - ROW_BITS'(1));
            m_out_col_reg <= OUT_COL_BITS'(s1_col_reg);
            m_last_reg    <= s1_flush_row_reg && s1_last_col_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;
    assign m_out_row = m_out_row_reg;
    assign m_out_col = m_out_col_reg;
    assign m_last    = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Column position stays inside the grid after every transaction.
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> ({1'b0, col_reg} < $past(w_eff)))
        else $error("column position left the grid");

    // A stalled stage-1 item keeps its position (no double write-back).
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_col_reg)
                                       && $stable(s1_row_reg)))
        else $error("stage 1 item changed while stalled");

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(s1_adv && s1_has_result))
        else $error("result overwritten while pending");

endmodule

// ===== hw/rtl/fnas_line_buf.sv =====
module fnas_line_buf (
    input  logic             aclk,
    input  fnas_pkg::lb_rd_t rd,
    input  fnas_pkg::lb_wr_t wr,
    output fnas_pkg::sample_t prev0_q,
    output fnas_pkg::sample_t prev1_q,
    output fnas_pkg::sample_t old_q
);
    import fnas_pkg::*;

    // Row above the incoming one, and the row above that.
    sample_t prev_mem [MAX_WIDTH];
    sample_t old_mem  [MAX_WIDTH];

    sample_t prev0_mem_reg;
    sample_t prev1_mem_reg;
    sample_t old_mem_reg;
    sample_t prev_byp_reg;
    sample_t old_byp_reg;
    logic    byp0_reg;
    logic    byp1_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            prev_mem[wr.addr] <= wr.prev_data;
            old_mem[wr.addr]  <= wr.old_data;
        end
    end

    // Read data holds while no new read is issued; a write to the same
    // entry on the read edge is forwarded.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            prev0_mem_reg <= prev_mem[rd.addr0];
            prev1_mem_reg <= prev_mem[rd.addr1];
            old_mem_reg   <= old_mem[rd.addr0];
            byp0_reg      <= wr.en && (wr.addr == rd.addr0);
            byp1_reg      <= wr.en && (wr.addr == rd.addr1);
            prev_byp_reg  <= wr.prev_data;
            old_byp_reg   <= wr.old_data;
        end
    end

    assign prev0_q = byp0_reg ? prev_byp_reg : prev0_mem_reg;
    assign prev1_q = byp1_reg ? prev_byp_reg : prev1_mem_reg;
    assign old_q   = byp0_reg ? old_byp_reg  : old_mem_reg;

endmodule
